>>> rtl/vfas_pkg.sv
package vfas_pkg;

	// Widths of the item fields.
	localparam int COORD_WIDTH   = 32;
	localparam int ANGLE_W       = 18;
	localparam int SUM_W         = 24;

	// Fan and CORDIC sizing.
	localparam int MAX_FACES     = 64;
	localparam int CORDIC_STAGES = 18;
	localparam int IDX_W         = 5;

	// Edge difference, normalized edge, product and CORDIC datapath widths.
	localparam int DW            = COORD_WIDTH + 1;
	localparam int NW            = 30;
	localparam int PW            = 2 * NW;
	localparam int DOTW          = PW + 1;
	localparam int CW            = PW + 2;
	localparam int ZW            = 34;

	// Normalization: magnitudes are shifted until both are below 2^29.
	localparam longint NORM_LIMIT = 64'd536870912;
	localparam int SH_MAX        = (COORD_WIDTH > 28) ? (COORD_WIDTH - 28) : 0;
	localparam int SW            = (SH_MAX < 1) ? 1 : $clog2(SH_MAX + 1);

	// Angle constants.
	localparam int PI_Q16        = 205887;
	localparam int HALF_PI_Q16   = 102944;
	localparam int HALF_PI_Q30   = 1686629713;
	localparam int ROUND_HALF    = 8192;
	localparam int ROUND_SHIFT   = 14;

	// Saturation limit of the running sum.
	localparam longint SUM_CAP_RAW = longint'(MAX_FACES) * longint'(PI_Q16);
	localparam logic [SUM_W-1:0] SUM_CAP = (SUM_CAP_RAW > ((64'd1 << SUM_W) - 64'd1)) ?
		{SUM_W{1'b1}} : SUM_W'(SUM_CAP_RAW);

	// Control bits that travel with an item through the front stages.
	typedef struct packed {
		logic valid;
		logic zero;
		logic last;
	} ctl_t;

	// Item state handed from cell to cell along the CORDIC chain.
	typedef struct packed {
		logic                 valid;
		logic                 zero;
		logic                 last;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	// Arctangent of 2^-i in Q2.30.
	function automatic logic [31:0] atan_q30(input logic [IDX_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'h3243F6A8;
			5'd1:    r = 32'h1DAC6705;
			5'd2:    r = 32'h0FADBAFC;
			5'd3:    r = 32'h07F56EA6;
			5'd4:    r = 32'h03FEAB76;
			5'd5:    r = 32'h01FFD55B;
			5'd6:    r = 32'h00FFFAAA;
			5'd7:    r = 32'h007FFF55;
			5'd8:    r = 32'h003FFFEA;
			5'd9:    r = 32'h001FFFFD;
			5'd10:   r = 32'h000FFFFF;
			5'd11:   r = 32'h0007FFFF;
			5'd12:   r = 32'h0003FFFF;
			5'd13:   r = 32'h0001FFFF;
			5'd14:   r = 32'h0000FFFF;
			5'd15:   r = 32'h00007FFF;
			5'd16:   r = 32'h00003FFF;
			5'd17:   r = 32'h00001FFF;
			5'd18:   r = 32'h00000FFF;
			5'd19:   r = 32'h000007FF;
			5'd20:   r = 32'h000003FF;
			5'd21:   r = 32'h000001FF;
			5'd22:   r = 32'h000000FF;
			5'd23:   r = 32'h0000007F;
			5'd24:   r = 32'h0000003F;
			5'd25:   r = 32'h0000001F;
			5'd26:   r = 32'h0000000F;
			5'd27:   r = 32'h00000008;
			5'd28:   r = 32'h00000004;
			5'd29:   r = 32'h00000002;
			5'd30:   r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/vfas_in_if.sv
interface vfas_in_if import vfas_pkg::*; ();

	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] center_x;
	logic signed [COORD_WIDTH-1:0] center_y;
	logic signed [COORD_WIDTH-1:0] first_nbr_x;
	logic signed [COORD_WIDTH-1:0] first_nbr_y;
	logic signed [COORD_WIDTH-1:0] second_nbr_x;
	logic signed [COORD_WIDTH-1:0] second_nbr_y;
	logic                          last_face;

	modport source (
		output valid, center_x, center_y, first_nbr_x, first_nbr_y,
			second_nbr_x, second_nbr_y, last_face,
		input  ready
	);

	modport sink (
		input  valid, center_x, center_y, first_nbr_x, first_nbr_y,
			second_nbr_x, second_nbr_y, last_face,
		output ready
	);

endinterface

>>> rtl/vfas_out_if.sv
interface vfas_out_if import vfas_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] face_angle;
	logic [SUM_W-1:0]   running_sum;
	logic               sum_done;

	modport source (
		output valid, face_angle, running_sum, sum_done,
		input  ready
	);

	modport sink (
		input  valid, face_angle, running_sum, sum_done,
		output ready
	);

endinterface

>>> rtl/vertex_fan_angle_sum_top.sv
// Channel   Role     Payload
// faces     sink     center_x/y, first_nbr_x/y, second_nbr_x/y, last_face
// results   source   face_angle, running_sum, sum_done
//
// One item per cycle is accepted while en is high; an item passes 5 front stages,
// the CORDIC cells (CORDIC_STAGES), one rounding stage and the result register.
// The pipeline holds as a whole while the result register is full and not taken,
// so faces.ready follows results.ready when a result is waiting.
// Reset clears every valid bit and the angle accumulator.
module vertex_fan_angle_sum_top import vfas_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	vfas_in_if.sink    faces,
	vfas_out_if.source results
);

	logic    en;
	cordic_t chain [CORDIC_STAGES+1];

	// Edge vectors, normalization, dot and cross, start vector.
	vfas_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.faces  (faces),
		.head   (chain[0])
	);

	// Row of CORDIC cells, one rotation each.
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		vfas_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.idx    (IDX_W'(g)),
			.d      (chain[g]),
			.q      (chain[g+1])
		);
	end

	// Rounding, fan accumulation and result register.
	vfas_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.tail    (chain[CORDIC_STAGES]),
		.en      (en),
		.results (results)
	);

	// The input side stalls only when a finished result waits.
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		faces.ready == (!results.valid || results.ready))
		else $error("input ready does not follow the result register");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.face_angle <= ANGLE_W'(PI_Q16))
		else $error("face angle above pi");

	a_sum_cap: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.running_sum <= SUM_CAP)
		else $error("running sum above its saturation limit");

	a_sum_covers_angle: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.running_sum >= SUM_W'(results.face_angle))
		else $error("running sum smaller than the face angle it includes");

endmodule

>>> rtl/vfas_front.sv
module vfas_front import vfas_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	vfas_in_if.sink faces,
	output cordic_t head
);

	// Magnitude of an edge component.
	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	// Least shift that brings the OR of both magnitudes below the limit.
	function automatic logic [SW-1:0] shift_for(input logic [DW-1:0] m);
		logic [SW-1:0] sel;
		sel = SW'(SH_MAX);
		for (int s = SH_MAX; s >= 0; s--) begin
			if (64'(m >> s) < NORM_LIMIT) begin
				sel = SW'(s);
			end
		end
		return sel;
	endfunction

	// Truncating shift of the magnitude, sign kept.
	function automatic logic signed [NW-1:0] norm(input logic signed [DW-1:0] v,
		input logic [SW-1:0] s);
		logic [DW-1:0]        sh;
		logic signed [NW-1:0] m;
		sh = mag(v) >> s;
		m  = $signed(NW'(sh));
		return v[DW-1] ? -m : m;
	endfunction

	ctl_t                    ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [DW-1:0]    e1x_s1, e1y_s1, e2x_s1, e2y_s1;
	logic signed [NW-1:0]    n1x_s2, n1y_s2, n2x_s2, n2y_s2;
	logic signed [PW-1:0]    pxx_s3, pyy_s3, pxy_s3, pyx_s3;
	logic signed [DOTW-1:0]  dot_s4, crs_s4;
	cordic_t                 head_s5;

	logic [SW-1:0]           sh1, sh2;
	logic                    zero1;
	logic signed [DOTW-1:0]  crs_abs;

	assign faces.ready = en;

	// Control bits of each front stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: faces.valid, zero: 1'b0, last: faces.last_face};
			ctl_s2 <= '{valid: ctl_s1.valid, zero: zero1, last: ctl_s1.last};
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// Stage 1: edge vectors from the centre.
	always_ff @(posedge clk) begin
		if (en) begin
			e1x_s1 <= DW'(faces.first_nbr_x) - DW'(faces.center_x);
			e1y_s1 <= DW'(faces.first_nbr_y) - DW'(faces.center_y);
			e2x_s1 <= DW'(faces.second_nbr_x) - DW'(faces.center_x);
			e2y_s1 <= DW'(faces.second_nbr_y) - DW'(faces.center_y);
		end
	end

	// Stage 2: zero-length test and per-edge normalization.
	always_comb begin
		zero1 = (e1x_s1 == '0 && e1y_s1 == '0) || (e2x_s1 == '0 && e2y_s1 == '0);
		sh1   = shift_for(mag(e1x_s1) | mag(e1y_s1));
		sh2   = shift_for(mag(e2x_s1) | mag(e2y_s1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1x_s2 <= norm(e1x_s1, sh1);
			n1y_s2 <= norm(e1y_s1, sh1);
			n2x_s2 <= norm(e2x_s1, sh2);
			n2y_s2 <= norm(e2y_s1, sh2);
		end
	end

	// Stage 3: the four partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s3 <= PW'(n1x_s2) * PW'(n2x_s2);
			pyy_s3 <= PW'(n1y_s2) * PW'(n2y_s2);
			pxy_s3 <= PW'(n1x_s2) * PW'(n2y_s2);
			pyx_s3 <= PW'(n1y_s2) * PW'(n2x_s2);
		end
	end

	// Stage 4: dot and cross products.
	always_ff @(posedge clk) begin
		if (en) begin
			dot_s4 <= DOTW'(pxx_s3) + DOTW'(pyy_s3);
			crs_s4 <= DOTW'(pxy_s3) - DOTW'(pyx_s3);
		end
	end

	// Stage 5: start vector, turned by a quarter when the dot is negative.
	assign crs_abs = crs_s4[DOTW-1] ? -crs_s4 : crs_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_s5 <= '0;
		end else if (en) begin
			head_s5.valid <= ctl_s4.valid;
			head_s5.zero  <= ctl_s4.zero;
			head_s5.last  <= ctl_s4.last;
			if (dot_s4[DOTW-1]) begin
				head_s5.x <= CW'(crs_abs);
				head_s5.y <= -CW'(dot_s4);
				head_s5.z <= ZW'(HALF_PI_Q30);
			end else begin
				head_s5.x <= CW'(dot_s4);
				head_s5.y <= CW'(crs_abs);
				head_s5.z <= '0;
			end
		end
	end

	assign head = head_s5;

endmodule

>>> rtl/vfas_cordic_cell.sv
module vfas_cordic_cell import vfas_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [IDX_W-1:0] idx,
	input  cordic_t          d,
	output cordic_t          q
);

	cordic_t              stage_q;
	cordic_t              nxt;
	logic signed [CW-1:0] dx, dy;
	logic signed [ZW-1:0] step;

	// One vectoring rotation: drive y toward zero and track the angle in z.
	always_comb begin
		dx   = d.y >>> idx;
		dy   = d.x >>> idx;
		step = ZW'(atan_q30(idx));
		nxt  = d;
		if (d.y > 0) begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + step;
		end else begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else if (en) begin
			stage_q <= nxt;
		end
	end

	assign q = stage_q;

endmodule

>>> rtl/vfas_accum.sv
module vfas_accum import vfas_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cordic_t       tail,
	output logic          en,
	vfas_out_if.source    results
);

	logic               valid_s6;
	logic               last_s6;
	logic [ANGLE_W-1:0] angle_s6;

	logic               out_valid_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [SUM_W-1:0]   sum_q;
	logic               done_q;
	logic [SUM_W-1:0]   acc_q;

	logic signed [ZW-1:0] zc, zr;
	logic [ANGLE_W-1:0]   angle;
	logic [SUM_W:0]       sum_wide;
	logic [SUM_W-1:0]     sum;

	// The whole pipeline moves whenever the result register can take an item.
	assign en = !out_valid_q || results.ready;

	// Clamp at zero, round Q2.30 to Q2.16, clamp at pi; a zero-length edge gives pi/2.
	always_comb begin
		zc = tail.z[ZW-1] ? '0 : tail.z;
		zr = (zc + ZW'(ROUND_HALF)) >>> ROUND_SHIFT;
		if (tail.zero) begin
			angle = ANGLE_W'(HALF_PI_Q16);
		end else if (zr > ZW'(PI_Q16)) begin
			angle = ANGLE_W'(PI_Q16);
		end else begin
			angle = zr[ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s6 <= angle;
			last_s6  <= tail.last;
		end
	end

	// Saturating sum of the fan.
	always_comb begin
		sum_wide = {1'b0, acc_q} + (SUM_W + 1)'(angle_s6);
		sum      = (sum_wide > (SUM_W + 1)'(SUM_CAP)) ? SUM_CAP : sum_wide[SUM_W-1:0];
	end

	// Result register and accumulator; the accumulator clears after the last face.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else if (en) begin
			out_valid_q <= valid_s6;
			if (valid_s6) begin
				acc_q <= last_s6 ? '0 : sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s6) begin
			angle_q <= angle_s6;
			sum_q   <= sum;
			done_q  <= last_s6;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.face_angle  = angle_q;
	assign results.running_sum = sum_q;
	assign results.sum_done    = done_q;

endmodule
